// ===== design/range_table_offset_lookup_assert.svh =====
// assertion macros for the range table offset lookup block
// expects clk and arst_n in the scope of the module that uses them
`ifndef RANGE_TABLE_OFFSET_LOOKUP_ASSERT_SVH
`define RANGE_TABLE_OFFSET_LOOKUP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RTOL_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rtol: invariant violated");

// consequence holds in the same cycle as the antecedent
`define RTOL_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtol: same-cycle check failed");

// consequence holds in the cycle after the antecedent
`define RTOL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtol: next-cycle check failed");

`endif

// ===== design/rtol_pkg.sv =====
// shared sizes, codes and types for the range table offset lookup block
// no dependencies
`timescale 1ns / 1ps

package rtol_pkg;

	// table sizes
	localparam int MAX_REGIONS = 16;
	localparam int MAX_ENTRIES = 64;

	localparam int RIDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int RCNT_W = $clog2(MAX_REGIONS + 1);
	localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);

	// function codes
	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_OVERLAP = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	// one distance region
	typedef struct packed {
		logic [15:0] lo;
		logic [15:0] hi;
	} region_t;

	// one height entry
	typedef struct packed {
		logic [RIDX_W-1:0] owner;
		logic [15:0]       hlo;
		logic [15:0]       hhi;
		logic [15:0]       pitch;
		logic [15:0]       yaw;
	} entry_t;

	// transaction token walking the cell rows; a lookup carries its point as lo = hi
	typedef struct packed {
		logic              insert;
		logic [15:0]       dlo;
		logic [15:0]       dhi;
		logic [15:0]       hlo;
		logic [15:0]       hhi;
		logic [15:0]       pitch;
		logic [15:0]       yaw;
		logic              found;
		logic [RIDX_W-1:0] ridx;
		logic              hit;
	} token_t;

endpackage

// ===== design/rtol_region_cell.sv =====
// one distance region cell: holds a region and tests the passing token against it
// depends on rtol_pkg
`timescale 1ns / 1ps

module rtol_region_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       live,
	input  logic [rtol_pkg::RIDX_W-1:0] idx,
	input  logic                       we,
	input  rtol_pkg::region_t          wr_data,
	input  logic                       valid_i,
	input  rtol_pkg::token_t           tok_i,
	output logic                       valid_o,
	output rtol_pkg::token_t           tok_o
);

	rtol_pkg::region_t region_q;
	rtol_pkg::token_t  tok_next;
	rtol_pkg::token_t  tok_q;
	logic              valid_q;
	logic              match;

	// stored region, written on append
	always_ff @(posedge clk) begin
		if (we) begin
			region_q <= wr_data;
		end
	end

	// first overlapping region claims the token
	always_comb begin
		match = live && !tok_i.found && (region_q.lo <= tok_i.dhi) && (tok_i.dlo <= region_q.hi);
		tok_next = tok_i;
		if (match) begin
			tok_next.found = 1'b1;
			tok_next.ridx  = idx;
		end
	end

	// hand token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_next;
	end

	assign valid_o = valid_q;
	assign tok_o   = tok_q;

endmodule

// ===== design/rtol_entry_cell.sv =====
// one height entry cell: holds an entry and tests the passing token against it
// depends on rtol_pkg
`timescale 1ns / 1ps

module rtol_entry_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             live,
	input  logic             we,
	input  rtol_pkg::entry_t wr_data,
	input  logic             valid_i,
	input  rtol_pkg::token_t tok_i,
	output logic             valid_o,
	output rtol_pkg::token_t tok_o
);

	rtol_pkg::entry_t entry_q;
	rtol_pkg::token_t tok_next;
	rtol_pkg::token_t tok_q;
	logic             valid_q;
	logic             match;

	// stored entry, written on append
	always_ff @(posedge clk) begin
		if (we) begin
			entry_q <= wr_data;
		end
	end

	// first entry of the chosen region whose height range meets the token
	always_comb begin
		match = live && tok_i.found && !tok_i.hit && (entry_q.owner == tok_i.ridx)
			&& ($signed(entry_q.hlo) <= $signed(tok_i.hhi))
			&& ($signed(tok_i.hlo) <= $signed(entry_q.hhi));
		tok_next = tok_i;
		if (match) begin
			tok_next.hit = 1'b1;
			if (!tok_i.insert) begin
				tok_next.pitch = entry_q.pitch;
				tok_next.yaw   = entry_q.yaw;
			end
		end
	end

	// hand token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_next;
	end

	assign valid_o = valid_q;
	assign tok_o   = tok_q;

endmodule

// ===== design/range_table_offset_lookup.sv =====
// Range table offset lookup. One transaction at a time: each accepted item becomes a token
// that walks a row of MAX_REGIONS region cells and then a row of MAX_ENTRIES entry cells, one
// cell per cycle, and the result register loads as the token leaves the last entry cell. The
// next item is taken once the token has left the last entry cell and the result register is
// free. Inserts are committed as the token leaves the row, so the next item always sees the
// updated table. The table is empty after reset and needs no clearing time.
// depends on rtol_pkg, rtol_region_cell, rtol_entry_cell, range_table_offset_lookup_assert.svh
`timescale 1ns / 1ps

`include "range_table_offset_lookup_assert.svh"

module range_table_offset_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] dist_low,
	input  logic [15:0] dist_high,
	input  logic signed [15:0] height_low,
	input  logic signed [15:0] height_high,
	input  logic signed [15:0] pitch_in,
	input  logic signed [15:0] yaw_in,
	input  logic [15:0] query_dist,
	input  logic signed [15:0] query_height,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        hit,
	output logic signed [15:0] pitch_out,
	output logic signed [15:0] yaw_out
);

	logic                          busy_q;
	logic                          out_valid_q;
	logic [1:0]                    status_q;
	logic                          hit_q;
	logic [15:0]                   pitch_q;
	logic [15:0]                   yaw_q;
	logic [rtol_pkg::RCNT_W-1:0]   region_count_q;
	logic [rtol_pkg::ECNT_W-1:0]   entry_count_q;

	logic                          accept;
	rtol_pkg::token_t              tok_in;

	logic                          rv [rtol_pkg::MAX_REGIONS+1];
	rtol_pkg::token_t              rt [rtol_pkg::MAX_REGIONS+1];
	logic                          ev [rtol_pkg::MAX_ENTRIES+1];
	rtol_pkg::token_t              et [rtol_pkg::MAX_ENTRIES+1];

	rtol_pkg::token_t              tail;
	logic                          tail_v;
	logic                          rfull;
	logic                          efull;
	logic [1:0]                    st;
	logic                          commit;
	logic                          region_we;
	logic                          entry_we;
	rtol_pkg::region_t             region_wr;
	rtol_pkg::entry_t              entry_wr;

	// input handshake and token build
	assign accept   = in_valid && in_ready;
	assign in_ready = !busy_q && (!out_valid_q || out_ready);

	always_comb begin
		tok_in = '0;
		tok_in.insert = (func == rtol_pkg::FUNC_INSERT);
		if (func == rtol_pkg::FUNC_INSERT) begin
			tok_in.dlo   = dist_low;
			tok_in.dhi   = dist_high;
			tok_in.hlo   = height_low;
			tok_in.hhi   = height_high;
			tok_in.pitch = pitch_in;
			tok_in.yaw   = yaw_in;
		end else begin
			tok_in.dlo = query_dist;
			tok_in.dhi = query_dist;
			tok_in.hlo = query_height;
			tok_in.hhi = query_height;
		end
	end

	assign rv[0] = accept;
	assign rt[0] = tok_in;

	// row of region cells
	for (genvar i = 0; i < rtol_pkg::MAX_REGIONS; i++) begin : g_region
		rtol_region_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.live    (rtol_pkg::RCNT_W'(i) < region_count_q),
			.idx     (rtol_pkg::RIDX_W'(i)),
			.we      (region_we && (region_count_q == rtol_pkg::RCNT_W'(i))),
			.wr_data (region_wr),
			.valid_i (rv[i]),
			.tok_i   (rt[i]),
			.valid_o (rv[i+1]),
			.tok_o   (rt[i+1])
		);
	end

	assign ev[0] = rv[rtol_pkg::MAX_REGIONS];
	assign et[0] = rt[rtol_pkg::MAX_REGIONS];

	// row of entry cells
	for (genvar j = 0; j < rtol_pkg::MAX_ENTRIES; j++) begin : g_entry
		rtol_entry_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.live    (rtol_pkg::ECNT_W'(j) < entry_count_q),
			.we      (entry_we && (entry_count_q == rtol_pkg::ECNT_W'(j))),
			.wr_data (entry_wr),
			.valid_i (ev[j]),
			.tok_i   (et[j]),
			.valid_o (ev[j+1]),
			.tok_o   (et[j+1])
		);
	end

	// decision on the token leaving the last entry cell
	assign tail_v = ev[rtol_pkg::MAX_ENTRIES];
	assign tail   = et[rtol_pkg::MAX_ENTRIES];
	assign rfull  = (region_count_q == rtol_pkg::RCNT_W'(rtol_pkg::MAX_REGIONS));
	assign efull  = (entry_count_q == rtol_pkg::ECNT_W'(rtol_pkg::MAX_ENTRIES));

	always_comb begin
		st = rtol_pkg::STATUS_DONE;
		if (tail.insert) begin
			if (tail.found) begin
				if (tail.hit) begin
					st = rtol_pkg::STATUS_OVERLAP;
				end else if (efull) begin
					st = rtol_pkg::STATUS_FULL;
				end
			end else if (rfull || efull) begin
				st = rtol_pkg::STATUS_FULL;
			end
		end
	end

	assign commit    = tail_v && tail.insert && (st == rtol_pkg::STATUS_DONE);
	assign region_we = commit && !tail.found;
	assign entry_we  = commit;

	// append data for the write strobes
	always_comb begin
		region_wr.lo = tail.dlo;
		region_wr.hi = tail.dhi;
		entry_wr.owner = tail.found ? tail.ridx : rtol_pkg::RIDX_W'(region_count_q);
		entry_wr.hlo   = tail.hlo;
		entry_wr.hhi   = tail.hhi;
		entry_wr.pitch = tail.pitch;
		entry_wr.yaw   = tail.yaw;
	end

	// control, fill counts and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			region_count_q <= '0;
			entry_count_q  <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail_v) begin
				busy_q <= 1'b0;
			end
			if (tail_v) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (region_we) begin
				region_count_q <= region_count_q + rtol_pkg::RCNT_W'(1);
			end
			if (entry_we) begin
				entry_count_q <= entry_count_q + rtol_pkg::ECNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_v) begin
			status_q <= st;
			hit_q    <= !tail.insert && tail.hit;
			pitch_q  <= (!tail.insert && tail.hit) ? tail.pitch : 16'd0;
			yaw_q    <= (!tail.insert && tail.hit) ? tail.yaw : 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign hit       = hit_q;
	assign pitch_out = pitch_q;
	assign yaw_out   = yaw_q;

	// every region owns at least one entry
	`RTOL_ASSERT_HOLDS(a_region_le_entry, 32'(region_count_q) <= 32'(entry_count_q))
	// a token only leaves the row while a transaction is open
	`RTOL_ASSERT_IMPLIES(a_tail_while_busy, tail_v, busy_q)
	// an accepted item leaves the block busy with a free result register
	`RTOL_ASSERT_NEXT(a_accept_busy, accept, busy_q && !out_valid_q)
	// no append into a full entry row or a full region row
	`RTOL_ASSERT_IMPLIES(a_no_entry_overflow, entry_we, !efull && !(region_we && rfull))

endmodule

// ===== sim/tb.sv =====
// self-checking bench for range_table_offset_lookup: a directed table of inserts and lookups,
// then random transactions scored against an in-bench model of the two-level range table
// depends on rtol_pkg and range_table_offset_lookup
`timescale 1ns / 1ps

module tb;

	localparam int HALF_PERIOD      = 2;
	localparam int RESET_CYCLES     = 9;
	localparam int RANDOM_PER_PHASE = 500;
	localparam int HOLD_AFTER       = 300;
	localparam int LONG_HOLD        = 500;
	localparam int DRAIN_CYCLES     = 100;
	localparam int CYCLE_LIMIT      = 1000000;

	// one input transaction, fields as on the ports
	typedef struct packed {
		logic        func;
		logic [15:0] dist_low;
		logic [15:0] dist_high;
		logic [15:0] height_low;
		logic [15:0] height_high;
		logic [15:0] pitch_in;
		logic [15:0] yaw_in;
		logic [15:0] query_dist;
		logic [15:0] query_height;
	} request_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [15:0] pitch;
		logic [15:0] yaw;
	} offsets_t;

	// directed row: typed set means the result is written out by hand
	typedef struct packed {
		request_t req;
		logic     typed;
		offsets_t want;
	} directed_row_t;

	localparam offsets_t MISS = '{rtol_pkg::STATUS_DONE, 1'b0, 16'h0, 16'h0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = rtol_pkg::FUNC_LOOKUP;
	logic [15:0] dist_low = 16'h0;
	logic [15:0] dist_high = 16'h0;
	logic signed [15:0] height_low = 16'sh0;
	logic signed [15:0] height_high = 16'sh0;
	logic signed [15:0] pitch_in = 16'sh0;
	logic signed [15:0] yaw_in = 16'sh0;
	logic [15:0] query_dist = 16'h0;
	logic signed [15:0] query_height = 16'sh0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic        hit;
	logic signed [15:0] pitch_out;
	logic signed [15:0] yaw_out;

	// bench copy of the table
	int          zone_lo [rtol_pkg::MAX_REGIONS];
	int          zone_hi [rtol_pkg::MAX_REGIONS];
	int          zone_total = 0;
	int          cell_zone [rtol_pkg::MAX_ENTRIES];
	int          cell_hlo [rtol_pkg::MAX_ENTRIES];
	int          cell_hhi [rtol_pkg::MAX_ENTRIES];
	logic [15:0] cell_pitch [rtol_pkg::MAX_ENTRIES];
	logic [15:0] cell_yaw [rtol_pkg::MAX_ENTRIES];
	int          cell_total = 0;

	offsets_t    expected_offsets [$];
	int          errors = 0;
	int          results_seen = 0;
	int          hold_left = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	// extremes, inclusive ends, inverted ranges, overlap rejection
	directed_row_t directed_rows [0:20] = '{
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h0}, 1'b1, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'h8000}, 1'b1, MISS},
		'{'{rtol_pkg::FUNC_INSERT, 16'h0, 16'h0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
			16'h0, 16'h0}, 1'b1, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h8000},
			1'b1, '{rtol_pkg::STATUS_DONE, 1'b1, 16'h7FFF, 16'h8000}},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h7FFF},
			1'b1, '{rtol_pkg::STATUS_DONE, 1'b1, 16'h7FFF, 16'h8000}},
		'{'{rtol_pkg::FUNC_INSERT, 16'd0, 16'd10, 16'd5, 16'd5, 16'd9, 16'd9,
			16'h0, 16'h0},
			1'b1, '{rtol_pkg::STATUS_OVERLAP, 1'b0, 16'h0, 16'h0}},
		'{'{rtol_pkg::FUNC_INSERT, 16'd100, 16'd50, 16'd10, 16'd20, 16'd1, 16'd2,
			16'h0, 16'h0}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd75, 16'd15}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_INSERT, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 16'h0001,
			16'h0, 16'h0}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_INSERT, 16'hFFFF, 16'hFFFF, 16'd10, 16'd5, 16'd3, 16'd4,
			16'h0, 16'h0}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'hFFFF, 16'd7}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'hFFFF, 16'd0}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_INSERT, 16'd60000, 16'hFFFF, 16'd0, 16'd100, 16'd5, 16'd6,
			16'h0, 16'h0}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_INSERT, 16'd40, 16'd200, 16'd10, 16'd20, 16'd7, 16'd8,
			16'h0, 16'h0}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_INSERT, 16'd1000, 16'd2000, 16'hFED4, 16'hFF9C, 16'd1234, 16'hFB2E,
			16'h0, 16'h0}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd1000, 16'hFED4}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd2000, 16'hFF9C}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd2001, 16'hFF9C}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd1500, 16'hFF9D}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_INSERT, 16'd1500, 16'd1500, 16'hFF9D, 16'hFFCE, 16'd11, 16'd12,
			16'h0, 16'h0}, 1'b0, MISS},
		'{'{rtol_pkg::FUNC_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd1500, 16'hFF9D}, 1'b0, MISS}
	};

	range_table_offset_lookup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.dist_low     (dist_low),
		.dist_high    (dist_high),
		.height_low   (height_low),
		.height_high  (height_high),
		.pitch_in     (pitch_in),
		.yaw_in       (yaw_in),
		.query_dist   (query_dist),
		.query_height (query_height),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.hit          (hit),
		.pitch_out    (pitch_out),
		.yaw_out      (yaw_out)
	);

	always #HALF_PERIOD clk = ~clk;

	// timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// table model: returns the offsets of one transaction and applies inserts
	function automatic offsets_t predict_offsets(request_t rq);
		offsets_t res;
		int       dl, dh, hl, hh, qd, qh, r, e;
		logic     found;
		res = '0;
		found = 1'b0;
		r = 0;
		if (rq.func == rtol_pkg::FUNC_INSERT) begin
			dl = int'(rq.dist_low);
			dh = int'(rq.dist_high);
			hl = int'($signed(rq.height_low));
			hh = int'($signed(rq.height_high));
			// first region whose distance range overlaps
			while (r < zone_total && !found) begin
				if (zone_lo[r] <= dh && dl <= zone_hi[r]) begin
					found = 1'b1;
				end else begin
					r++;
				end
			end
			if (found) begin
				for (e = 0; e < cell_total; e++) begin
					if (cell_zone[e] == r && cell_hlo[e] <= hh && hl <= cell_hhi[e]) begin
						res.status = rtol_pkg::STATUS_OVERLAP;
					end
				end
			end else if (zone_total >= rtol_pkg::MAX_REGIONS) begin
				res.status = rtol_pkg::STATUS_FULL;
			end
			if (res.status == rtol_pkg::STATUS_DONE && cell_total >= rtol_pkg::MAX_ENTRIES) begin
				res.status = rtol_pkg::STATUS_FULL;
			end
			// commit only a clean insert
			if (res.status == rtol_pkg::STATUS_DONE) begin
				if (!found) begin
					r = zone_total;
					zone_lo[r] = dl;
					zone_hi[r] = dh;
					zone_total++;
				end
				cell_zone[cell_total] = r;
				cell_hlo[cell_total] = hl;
				cell_hhi[cell_total] = hh;
				cell_pitch[cell_total] = rq.pitch_in;
				cell_yaw[cell_total] = rq.yaw_in;
				cell_total++;
			end
		end else begin
			qd = int'(rq.query_dist);
			qh = int'($signed(rq.query_height));
			while (r < zone_total && !found) begin
				if (zone_lo[r] <= qd && qd <= zone_hi[r]) begin
					found = 1'b1;
				end else begin
					r++;
				end
			end
			// first entry of that region holding the height
			if (found) begin
				e = 0;
				while (e < cell_total && !res.hit) begin
					if (cell_zone[e] == r && cell_hlo[e] <= qh && qh <= cell_hhi[e]) begin
						res.hit = 1'b1;
						res.pitch = cell_pitch[e];
						res.yaw = cell_yaw[e];
					end
					e++;
				end
			end
		end
		return res;
	endfunction

	function automatic logic [15:0] rand16();
		logic [31:0] v;
		v = $urandom;
		return v[15:0];
	endfunction

	// point in an inclusive range, ends favored; inverted ranges give their low end
	function automatic int pick_in(int lo, int hi);
		int roll;
		roll = $urandom_range(0, 3);
		if (lo > hi) return lo;
		if (roll == 0) return lo;
		if (roll == 1) return hi;
		return lo + int'($urandom_range(hi - lo, 0));
	endfunction

	// random transaction, mostly aimed at what the table already holds
	function automatic request_t random_request();
		request_t rq;
		int       r, e, v, lo, hi, pick;
		rq.func = rtol_pkg::FUNC_INSERT;
		rq.dist_low = rand16();
		rq.dist_high = rand16();
		rq.height_low = rand16();
		rq.height_high = rand16();
		rq.pitch_in = rand16();
		rq.yaw_in = rand16();
		rq.query_dist = rand16();
		rq.query_height = rand16();
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			rq.func = rtol_pkg::FUNC_LOOKUP;
			if (cell_total != 0 && $urandom_range(0, 99) < 75) begin
				e = $urandom_range(cell_total - 1, 0);
				r = cell_zone[e];
				v = pick_in(zone_lo[r], zone_hi[r]);
				rq.query_dist = v[15:0];
				v = pick_in(cell_hlo[e], cell_hhi[e]);
				rq.query_height = v[15:0];
			end
		end else begin
			pick = $urandom_range(0, 99);
			// distance: reuse a region, a narrow new range, or anything
			if (zone_total != 0 && pick < 55) begin
				r = $urandom_range(zone_total - 1, 0);
				if ($urandom_range(0, 1) == 0) begin
					lo = zone_lo[r];
					hi = zone_hi[r];
				end else begin
					lo = pick_in(zone_lo[r], zone_hi[r]);
					hi = lo;
				end
				rq.dist_low = lo[15:0];
				rq.dist_high = hi[15:0];
			end else if (pick < 95) begin
				lo = int'($urandom_range(65535, 0));
				hi = lo + int'($urandom_range(1500, 0));
				if (hi > 65535) hi = 65535;
				rq.dist_low = lo[15:0];
				rq.dist_high = hi[15:0];
			end
			// height: crowded window so overlaps are common, some inverted
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				lo = int'($urandom_range(4000, 0)) - 2000;
				hi = lo + int'($urandom_range(600, 0));
				rq.height_low = lo[15:0];
				rq.height_high = hi[15:0];
			end else if (pick < 80) begin
				lo = int'($urandom_range(4000, 0)) - 2000;
				hi = lo - int'($urandom_range(50, 1));
				rq.height_low = lo[15:0];
				rq.height_high = hi[15:0];
			end
		end
		return rq;
	endfunction

	// offer one transaction and log its expected result once accepted
	task automatic send_request(input request_t rq, input logic typed, input offsets_t want);
		offsets_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= rq.func;
		dist_low <= rq.dist_low;
		dist_high <= rq.dist_high;
		height_low <= rq.height_low;
		height_high <= rq.height_high;
		pitch_in <= rq.pitch_in;
		yaw_in <= rq.yaw_in;
		query_dist <= rq.query_dist;
		query_height <= rq.query_height;
		do @(posedge clk); while (!in_ready);
		predicted = predict_offsets(rq);
		expected_offsets = {expected_offsets, (typed ? want : predicted)};
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			errors++;
		end
	endtask

	// result side: score each transaction, random stalls plus one long hold-off
	always @(posedge clk) begin : drain_results
		offsets_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_offsets.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				want = expected_offsets.pop_front();
				check_field("status", int'(want.status), int'(status));
				check_field("hit", int'(want.hit), int'(hit));
				check_field("pitch_out", int'($signed(want.pitch)), int'(pitch_out));
				check_field("yaw_out", int'($signed(want.yaw)), int'(yaw_out));
			end
			if (results_seen == HOLD_AFTER) hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// stimulus
	initial begin : stimulus
		int i, ph, n;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 20;
		recv_idle_pct = 87;
		for (i = 0; i < $size(directed_rows); i++) begin
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		end
		for (ph = 0; ph < 3; ph++) begin
			// hold the sender until the block has drained
			in_valid <= 1'b0;
			while (expected_offsets.size() != 0) @(posedge clk);
			@(posedge clk);
			case (ph)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_request(random_request(), 1'b0, MISS);
			end
		end
		in_valid <= 1'b0;
		while (expected_offsets.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_offsets.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/rtol_pkg.sv
design/rtol_region_cell.sv
design/rtol_entry_cell.sv
design/range_table_offset_lookup.sv
sim/tb.sv
